[design/size_class_bitmap_allocator_macros.svh]
// assertion macros for the size class bitmap allocator checker
`ifndef SIZE_CLASS_BITMAP_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SCBA_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SCBA_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/scba_pkg.sv]
// shared types, constants and helper functions of the size class bitmap allocator
package scba_pkg;

   localparam int SLOTS_PER_CLASS  = 65536;
   localparam int BITMAP_WORD_BITS = 64;
   localparam int NUM_CLASSES      = 4;
   localparam int GROUPS_PER_CLASS = 16;
   localparam int LEAF_WORDS       = BITMAP_WORD_BITS * BITMAP_WORD_BITS;
   localparam int SLOT_W           = 16;

   localparam logic [7:0] MAX_SIDES = 8'd32;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [8:0] SLOT_BYTES_0 = 9'd92;
   localparam logic [8:0] SLOT_BYTES_1 = 9'd156;
   localparam logic [8:0] SLOT_BYTES_2 = 9'd220;
   localparam logic [8:0] SLOT_BYTES_3 = 9'd284;

   localparam logic [25:0] CLASS_BASE_1 = 26'(SLOTS_PER_CLASS * SLOT_BYTES_0);
   localparam logic [25:0] CLASS_BASE_2 = 26'(SLOTS_PER_CLASS * (SLOT_BYTES_0 + SLOT_BYTES_1));
   localparam logic [25:0] CLASS_BASE_3 =
      26'(SLOTS_PER_CLASS * (SLOT_BYTES_0 + SLOT_BYTES_1 + SLOT_BYTES_2));
   localparam logic [25:0] POOL_BYTES =
      26'(SLOTS_PER_CLASS * (SLOT_BYTES_0 + SLOT_BYTES_1 + SLOT_BYTES_2 + SLOT_BYTES_3));

   // floor(2^32 / slot size), good for a one-step correction on 25-bit dividends
   localparam logic [25:0] RECIP_0 = 26'((64'd1 << 32) / 64'(SLOT_BYTES_0));
   localparam logic [25:0] RECIP_1 = 26'((64'd1 << 32) / 64'(SLOT_BYTES_1));
   localparam logic [25:0] RECIP_2 = 26'((64'd1 << 32) / 64'(SLOT_BYTES_2));
   localparam logic [25:0] RECIP_3 = 26'((64'd1 << 32) / 64'(SLOT_BYTES_3));

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_SIDES,
      STATUS_EXHAUSTED,
      STATUS_OUTSIDE
   } status_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic alloc_top;
      logic alloc_leaf;
      logic alloc_write;
      logic free_class;
      logic free_mul;
      logic free_prod;
      logic free_slot;
      logic free_read;
      logic free_write;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic bad_sides;
      logic exhausted;
      logic outside;
      logic rsp_free;
   } stat_type;

   function automatic logic [8:0] slot_bytes(input logic [1:0] c);
      logic [8:0] r;
      unique case (c)
         2'd0: r = SLOT_BYTES_0;
         2'd1: r = SLOT_BYTES_1;
         2'd2: r = SLOT_BYTES_2;
         default: r = SLOT_BYTES_3;
      endcase
      return r;
   endfunction

   function automatic logic [25:0] class_base(input logic [1:0] c);
      logic [25:0] r;
      unique case (c)
         2'd0: r = '0;
         2'd1: r = CLASS_BASE_1;
         2'd2: r = CLASS_BASE_2;
         default: r = CLASS_BASE_3;
      endcase
      return r;
   endfunction

   function automatic logic [25:0] recip(input logic [1:0] c);
      logic [25:0] r;
      unique case (c)
         2'd0: r = RECIP_0;
         2'd1: r = RECIP_1;
         2'd2: r = RECIP_2;
         default: r = RECIP_3;
      endcase
      return r;
   endfunction

   // index of the lowest set bit, via isolate-and-encode
   function automatic logic [5:0] lowest_set(input logic [63:0] v);
      logic [63:0] iso;
      logic [5:0]  idx;
      iso = v & (~v + 64'd1);
      idx = '0;
      for (int i = 0; i < BITMAP_WORD_BITS; i++) begin
         if (iso[i]) idx = idx | 6'(i);
      end
      return idx;
   endfunction

   // reset contents of leaf word m of a group at position g4 inside its class
   function automatic logic [63:0] leaf_reset_word(input logic [3:0] g4, input logic [5:0] m);
      int first;
      logic [63:0] w;
      first = int'(g4) * LEAF_WORDS + int'(m) * BITMAP_WORD_BITS;
      if (first >= SLOTS_PER_CLASS) w = '0;
      else if (SLOTS_PER_CLASS - first >= BITMAP_WORD_BITS) w = '1;
      else w = (64'd1 << (SLOTS_PER_CLASS - first)) - 64'd1;
      return w;
   endfunction

   function automatic logic [63:0] mid_reset_word(input logic [3:0] g4);
      logic [63:0] w;
      w = '0;
      for (int m = 0; m < BITMAP_WORD_BITS; m++) begin
         w[m] = (leaf_reset_word(g4, 6'(m)) != '0);
      end
      return w;
   endfunction

   function automatic logic [63:0] top_reset_word();
      logic [63:0] w;
      w = '0;
      for (int g = 0; g < BITMAP_WORD_BITS; g++) begin
         w[g] = (mid_reset_word(4'(g)) != '0);
      end
      return w;
   endfunction

   localparam logic [63:0] TOP_RESET = top_reset_word();

endpackage

[design/scba_ctrl.sv]
// sequencer of the allocator: clearing pass, allocate and free step sequences
module scba_ctrl import scba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_mode,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     req_stall
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_TOP,
      ST_A_LEAF,
      ST_A_WRITE,
      ST_F_CLASS,
      ST_F_MUL,
      ST_F_PROD,
      ST_F_SLOT,
      ST_F_READ,
      ST_F_WRITE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff, req_stall_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_mode == MODE_FREE) ? ST_F_CLASS : ST_A_TOP;
            end
         end
         ST_A_TOP: begin
            cmd.alloc_top = 1'b1;
            state_in = (stat.bad_sides || stat.exhausted) ? ST_DONE : ST_A_LEAF;
         end
         ST_A_LEAF: begin
            cmd.alloc_leaf = 1'b1;
            state_in = ST_A_WRITE;
         end
         ST_A_WRITE: begin
            cmd.alloc_write = 1'b1;
            state_in = ST_DONE;
         end
         ST_F_CLASS: begin
            cmd.free_class = 1'b1;
            state_in = stat.outside ? ST_DONE : ST_F_MUL;
         end
         ST_F_MUL: begin
            cmd.free_mul = 1'b1;
            state_in = ST_F_PROD;
         end
         ST_F_PROD: begin
            cmd.free_prod = 1'b1;
            state_in = ST_F_SLOT;
         end
         ST_F_SLOT: begin
            cmd.free_slot = 1'b1;
            state_in = ST_F_READ;
         end
         ST_F_READ: begin
            cmd.free_read = 1'b1;
            state_in = ST_F_WRITE;
         end
         ST_F_WRITE: begin
            cmd.free_write = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      req_stall_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
      end
   end

   assign req_stall = req_stall_ff;

endmodule

[design/scba_dpath.sv]
// datapath of the allocator: bitmap memories, top word, divider and offset math
module scba_dpath import scba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [7:0]  req_side_count,
   input  logic [25:0] req_freed_offset,
   input  logic        rsp_stall,
   output stat_type    stat,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [25:0] rsp_slot_offset
);

   // bitmap storage
   logic [63:0] leaf_mem [LEAF_WORDS];
   logic [63:0] mid_mem  [BITMAP_WORD_BITS];
   logic [63:0] leaf_rd_ff, mid_rd_ff;

   // control registers
   logic [63:0] top_ff, top_in;
   logic [11:0] clear_cnt_ff, clear_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [7:0]        sides_ff, sides_in;
   logic [25:0]       offset_ff, offset_in;
   logic [1:0]        cls_ff, cls_in;
   logic [5:0]        grp_ff, grp_in;
   logic [5:0]        word_ff, word_in;
   logic [24:0]       rel_ff, rel_in;
   logic [15:0]       quot_ff, quot_in;
   logic [24:0]       prod_ff, prod_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   status_type        status_ff, status_in;
   logic              alloc_ok_ff, alloc_ok_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [25:0]       rsp_offset_ff, rsp_offset_in;

   // combinational
   logic [7:0]        sides_less;
   logic [1:0]        cls_alloc;
   logic [15:0]       avail;
   logic [5:0]        avail_idx;
   logic [5:0]        grp_alloc;
   logic [5:0]        word_alloc;
   logic [5:0]        bit_alloc;
   logic [SLOT_W-1:0] slot_alloc;
   logic [63:0]       leaf_cleared, mid_cleared;
   logic [1:0]        cls_free;
   logic [5:0]        grp_free;
   logic [50:0]       quot_full;
   logic [15:0]       mul_a;
   logic [8:0]        cls_bytes;
   logic [24:0]       remain;
   logic              bad_sides, exhausted, outside;
   logic              leaf_we, mid_we, leaf_re, mid_re;
   logic [11:0]       leaf_waddr, leaf_raddr;
   logic [5:0]        mid_waddr, mid_raddr;
   logic [63:0]       leaf_wdata, mid_wdata;

   always_comb begin
      // allocate side: class, group search in the top word
      sides_less = sides_ff - 8'd1;
      cls_alloc  = sides_less[4:3];
      avail      = top_ff[{cls_alloc, 4'd0} +: GROUPS_PER_CLASS];
      avail_idx  = lowest_set({48'd0, avail});
      grp_alloc  = {cls_alloc, avail_idx[3:0]};
      bad_sides  = (sides_ff == 8'd0) || (sides_ff > MAX_SIDES);
      exhausted  = (avail == 16'd0);
      word_alloc = lowest_set(mid_rd_ff);
      bit_alloc  = lowest_set(leaf_rd_ff);
      slot_alloc = {grp_ff[3:0], word_ff, bit_alloc};
      leaf_cleared = leaf_rd_ff & ~(64'd1 << bit_alloc);
      mid_cleared  = mid_rd_ff & ~(64'd1 << word_ff);

      // free side: class lookup against the pool layout
      if (offset_ff >= CLASS_BASE_3)      cls_free = 2'd3;
      else if (offset_ff >= CLASS_BASE_2) cls_free = 2'd2;
      else if (offset_ff >= CLASS_BASE_1) cls_free = 2'd1;
      else                                cls_free = 2'd0;
      outside   = (offset_ff >= POOL_BYTES);
      grp_free  = {cls_ff, slot_ff[15:12]};
      cls_bytes = slot_bytes(cls_ff);
      quot_full = 51'(rel_ff) * 51'(recip(cls_ff));
      remain    = rel_ff - prod_ff;
      mul_a     = cmd.alloc_write ? slot_alloc : quot_ff;

      sides_in  = cmd.capture ? req_side_count : sides_ff;
      offset_in = cmd.capture ? req_freed_offset : offset_ff;

      cls_in = cls_ff;
      if (cmd.alloc_top)       cls_in = cls_alloc;
      else if (cmd.free_class) cls_in = cls_free;

      grp_in  = cmd.alloc_top ? grp_alloc : grp_ff;
      word_in = cmd.alloc_leaf ? word_alloc : word_ff;
      rel_in  = cmd.free_class ? 25'(offset_ff - class_base(cls_free)) : rel_ff;
      quot_in = cmd.free_mul ? quot_full[47:32] : quot_ff;
      prod_in = (cmd.free_prod || cmd.alloc_write) ? 25'(mul_a) * 25'(cls_bytes) : prod_ff;

      slot_in = slot_ff;
      if (cmd.free_slot) slot_in = (remain >= 25'(cls_bytes)) ? quot_ff + 16'd1 : quot_ff;

      priority if (cmd.capture) status_in = STATUS_OK;
      else if (cmd.alloc_top) begin
         status_in = status_ff;
         if (bad_sides)      status_in = STATUS_BAD_SIDES;
         else if (exhausted) status_in = STATUS_EXHAUSTED;
      end else if (cmd.free_class && outside) status_in = STATUS_OUTSIDE;
      else status_in = status_ff;

      alloc_ok_in = alloc_ok_ff;
      if (cmd.capture)          alloc_ok_in = 1'b0;
      else if (cmd.alloc_write) alloc_ok_in = 1'b1;

      top_in = top_ff;
      if (cmd.alloc_write && (leaf_cleared == '0) && (mid_cleared == '0))
         top_in = top_ff & ~(64'd1 << grp_ff);
      else if (cmd.free_write)
         top_in = top_ff | (64'd1 << grp_free);

      clear_cnt_in = cmd.clear_step ? clear_cnt_ff + 12'd1 : clear_cnt_ff;

      // memory ports
      leaf_re    = cmd.alloc_leaf || cmd.free_read;
      leaf_raddr = cmd.alloc_leaf ? {grp_ff, word_alloc} : {grp_free, slot_ff[11:6]};
      mid_re     = cmd.alloc_top || cmd.free_read;
      mid_raddr  = cmd.alloc_top ? grp_alloc : grp_free;

      leaf_we    = cmd.clear_step || cmd.alloc_write || cmd.free_write;
      leaf_waddr = clear_cnt_ff;
      leaf_wdata = leaf_reset_word(clear_cnt_ff[9:6], clear_cnt_ff[5:0]);
      if (cmd.alloc_write) begin
         leaf_waddr = {grp_ff, word_ff};
         leaf_wdata = leaf_cleared;
      end else if (cmd.free_write) begin
         leaf_waddr = {grp_free, slot_ff[11:6]};
         leaf_wdata = leaf_rd_ff | (64'd1 << slot_ff[5:0]);
      end

      mid_we    = (cmd.clear_step && (clear_cnt_ff[11:6] == 6'd0))
                  || (cmd.alloc_write && (leaf_cleared == '0)) || cmd.free_write;
      mid_waddr = clear_cnt_ff[5:0];
      mid_wdata = mid_reset_word(clear_cnt_ff[3:0]);
      if (cmd.alloc_write) begin
         mid_waddr = grp_ff;
         mid_wdata = mid_cleared;
      end else if (cmd.free_write) begin
         mid_waddr = grp_free;
         mid_wdata = mid_rd_ff | (64'd1 << slot_ff[11:6]);
      end

      // result register
      rsp_valid_in  = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
      rsp_status_in = cmd.load_rsp ? status_ff : rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      if (cmd.load_rsp)
         rsp_offset_in = alloc_ok_ff ? class_base(cls_ff) + 26'(prod_ff) : 26'd0;
   end

   always_ff @(posedge clock) begin
      if (leaf_we) leaf_mem[leaf_waddr] <= leaf_wdata;
      if (leaf_re) leaf_rd_ff <= leaf_mem[leaf_raddr];
   end

   always_ff @(posedge clock) begin
      if (mid_we) mid_mem[mid_waddr] <= mid_wdata;
      if (mid_re) mid_rd_ff <= mid_mem[mid_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= TOP_RESET;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff       <= top_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sides_ff      <= sides_in;
      offset_ff     <= offset_in;
      cls_ff        <= cls_in;
      grp_ff        <= grp_in;
      word_ff       <= word_in;
      rel_ff        <= rel_in;
      quot_ff       <= quot_in;
      prod_ff       <= prod_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      alloc_ok_ff   <= alloc_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign stat.clear_done = (clear_cnt_ff == 12'(LEAF_WORDS - 1));
   assign stat.bad_sides  = bad_sides;
   assign stat.exhausted  = exhausted;
   assign stat.outside    = outside;
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_offset = rsp_offset_ff;

endmodule

[design/size_class_bitmap_allocator.sv]
// size class slab allocator with a three-level free bitmap, top level
// allocate: top, leaf and write steps, then the response (only the top step on a bad side
//   count or a full class); the next request is taken once the response is loaded
// free: class, multiply, product, slot, read and write steps (only class outside the pool),
//   then as above; the reciprocal divide and registered mid and leaf reads set these steps
// reset: synchronous; a clearing pass over the leaf memory follows, stall held high
module size_class_bitmap_allocator import scba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_side_count,
   input  logic [25:0] req_freed_offset,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [25:0] rsp_slot_offset
);

   // commands from the sequencer, status back from the datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: one request at a time
   // allocate walks top word -> mid word -> leaf word, each read registered,
   // then clears the leaf bit and folds emptiness up into mid and top
   // free finds the class by compare, the slot by a reciprocal multiply
   // with one correction step, then sets the bit at all three levels
   scba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // datapath: bitmap memories, top word register, arithmetic and the
   // response register, which holds a result while the next request is taken
   scba_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_side_count   (req_side_count),
      .req_freed_offset (req_freed_offset),
      .rsp_stall        (rsp_stall),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot_offset  (rsp_slot_offset)
   );

endmodule

[design/scba_checker.sv]
// port-level assertion checker for the allocator and its bind
`include "size_class_bitmap_allocator_macros.svh"

module scba_checker import scba_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [25:0] rsp_slot_offset
);

   `SCBA_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
   `SCBA_NEXT(a_one_request, req_valid && !req_stall, req_stall, "second request taken early")
   `SCBA_NEXT(a_no_early_rsp, req_valid && !req_stall && !rsp_valid, !rsp_valid, "response too soon")
   `SCBA_IMPLIES(a_offset_ok, rsp_valid && (rsp_slot_offset != 26'd0), rsp_status == STATUS_OK, "offset on failure")
   `SCBA_IMPLIES(a_offset_pool, rsp_valid, rsp_slot_offset < POOL_BYTES, "offset beyond pool")

endmodule

bind size_class_bitmap_allocator scba_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_slot_offset (rsp_slot_offset)
);

[dv/slab_free_map_checker.sv]
// checker that tracks the slab free bitmap and compares every allocator response
`timescale 1ns / 1ps
module slab_free_map_checker
   import scba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_side_count,
   input  logic [25:0] req_freed_offset,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [25:0] rsp_slot_offset,
   output int          open_count,
   output int          error_count
);

   typedef struct {
      status_type  status;
      logic [25:0] offset;
   } slab_rsp_type;

   // one means free at every level
   logic [63:0] top_map;
   logic [63:0] mid_map  [BITMAP_WORD_BITS];
   logic [63:0] leaf_map [LEAF_WORDS];

   slab_rsp_type expected_slab_rsp [$];

   function automatic int bytes_of(input int c);
      case (c)
         0:       return int'(SLOT_BYTES_0);
         1:       return int'(SLOT_BYTES_1);
         2:       return int'(SLOT_BYTES_2);
         default: return int'(SLOT_BYTES_3);
      endcase
   endfunction

   function automatic int class_origin(input int c);
      int sum;
      sum = 0;
      for (int k = 0; k < c && k < NUM_CLASSES; k++) sum += SLOTS_PER_CLASS * bytes_of(k);
      return sum;
   endfunction

   function automatic logic [5:0] lowest_one(input logic [63:0] v);
      for (int i = 0; i < BITMAP_WORD_BITS; i++) begin
         if (v[i]) return 6'(i);
      end
      return 6'd63;
   endfunction

   // slots at or above the class size start taken, all others free
   function automatic void clear_maps();
      int first;
      logic [63:0] w;
      top_map = '0;
      for (int g = 0; g < BITMAP_WORD_BITS; g++) begin
         mid_map[g] = '0;
         for (int m = 0; m < BITMAP_WORD_BITS; m++) begin
            first = (g % GROUPS_PER_CLASS) * LEAF_WORDS + m * BITMAP_WORD_BITS;
            if (first >= SLOTS_PER_CLASS) w = '0;
            else if (SLOTS_PER_CLASS - first >= BITMAP_WORD_BITS) w = '1;
            else w = (64'd1 << (SLOTS_PER_CLASS - first)) - 64'd1;
            leaf_map[g * BITMAP_WORD_BITS + m] = w;
            if (w != '0) mid_map[g][m] = 1'b1;
         end
         if (mid_map[g] != '0) top_map[g] = 1'b1;
      end
   endfunction

   function automatic slab_rsp_type predict_slab_response(input logic mode,
                                                          input logic [7:0] sides,
                                                          input logic [25:0] where);
      slab_rsp_type r;
      logic [63:0] avail;
      logic [5:0] g, m, b;
      int c, slot, rel;
      r.status = STATUS_OK;
      r.offset = '0;
      if (mode == MODE_ALLOC) begin
         if (sides == 8'd0 || sides > MAX_SIDES) begin
            r.status = STATUS_BAD_SIDES;
         end else begin
            c = (int'(sides) - 1) / 8;
            avail = top_map & (64'hFFFF << (c * GROUPS_PER_CLASS));
            if (avail == '0) begin
               r.status = STATUS_EXHAUSTED;
            end else begin
               g = lowest_one(avail);
               m = lowest_one(mid_map[g]);
               b = lowest_one(leaf_map[{g, m}]);
               leaf_map[{g, m}][b] = 1'b0;
               if (leaf_map[{g, m}] == '0) mid_map[g][m] = 1'b0;
               if (mid_map[g] == '0) top_map[g] = 1'b0;
               slot = (int'(g) - c * GROUPS_PER_CLASS) * LEAF_WORDS
                      + int'(m) * BITMAP_WORD_BITS + int'(b);
               r.offset = 26'(class_origin(c) + slot * bytes_of(c));
            end
         end
      end else if (int'(where) >= class_origin(NUM_CLASSES)) begin
         r.status = STATUS_OUTSIDE;
      end else begin
         c = 0;
         rel = int'(where);
         while (c < NUM_CLASSES - 1 && rel >= SLOTS_PER_CLASS * bytes_of(c)) begin
            rel -= SLOTS_PER_CLASS * bytes_of(c);
            c++;
         end
         slot = rel / bytes_of(c);
         g = 6'(c * GROUPS_PER_CLASS + slot / LEAF_WORDS);
         m = 6'(slot / BITMAP_WORD_BITS);
         b = 6'(slot);
         leaf_map[{g, m}][b] = 1'b1;
         mid_map[g][m] = 1'b1;
         top_map[g] = 1'b1;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      slab_rsp_type want;
      if (reset) begin
         clear_maps();
         expected_slab_rsp.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_slab_rsp.size() == 0) begin
               error_count++;
               $display("%0t: response with none pending, status %0d offset %0d",
                        $time, rsp_status, rsp_slot_offset);
            end else begin
               want = expected_slab_rsp.pop_front();
               if (rsp_status !== want.status) begin
                  error_count++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_slot_offset !== want.offset) begin
                  error_count++;
                  $display("%0t: slot_offset mismatch, expected %0d, actual %0d",
                           $time, want.offset, rsp_slot_offset);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_slab_rsp.push_back(predict_slab_response(req_mode, req_side_count,
                                                              req_freed_offset));
      end
      open_count = expected_slab_rsp.size();
   end

endmodule

[dv/testbench.sv]
// top of the slab allocator testbench: clock, reset, request and stall generation, verdict
`timescale 1ns / 1ps
module testbench;
   import scba_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic [7:0]  req_side_count;
   logic [25:0] req_freed_offset;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [25:0] rsp_slot_offset;

   int open_count;
   int error_count;

   // while set, neither side inserts gaps
   bit quiet;

   // allocations sent per class, used to aim frees at slots that are likely taken
   int placed [NUM_CLASSES];

   size_class_bitmap_allocator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_side_count   (req_side_count),
      .req_freed_offset (req_freed_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_offset  (rsp_slot_offset)
   );

   // models the bitmap, predicts each response and counts mismatches
   slab_free_map_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_side_count   (req_side_count),
      .req_freed_offset (req_freed_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_offset  (rsp_slot_offset),
      .open_count       (open_count),
      .error_count      (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop, far above the slowest legal run with the longest gaps and stalls
   initial begin
      #80_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // gap length: mostly none or short, now and then long
   function automatic int idle_cycles();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // byte address of a slot, optionally pointing somewhere inside it
   function automatic logic [25:0] slot_address(input int cls, input int slot, input bit scatter);
      int start, size;
      case (cls)
         0: begin
            start = 0;
            size  = int'(SLOT_BYTES_0);
         end
         1: begin
            start = int'(CLASS_BASE_1);
            size  = int'(SLOT_BYTES_1);
         end
         2: begin
            start = int'(CLASS_BASE_2);
            size  = int'(SLOT_BYTES_2);
         end
         default: begin
            start = int'(CLASS_BASE_3);
            size  = int'(SLOT_BYTES_3);
         end
      endcase
      return 26'(start + slot * size + (scatter ? int'($urandom_range(0, size - 1)) : 0));
   endfunction

   // one request: optional gap, then hold it until the allocator takes it
   task automatic send_request(input logic mode, input logic [7:0] sides,
                               input logic [25:0] where);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_side_count   <= sides;
      req_freed_offset <= where;
      do @(posedge clock); while (req_stall);
      if (mode == MODE_ALLOC && sides != 8'd0 && sides <= MAX_SIDES) begin
         if (placed[(int'(sides) - 1) / 8] < SLOTS_PER_CLASS)
            placed[(int'(sides) - 1) / 8]++;
      end
   endtask

   // response side stalls in random bursts
   initial begin : rsp_stall_gen
      int hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) hold = idle_cycles();
         end
      end
   end

   initial begin : stimulus
      int pick;
      int cls;
      int slot;
      logic [7:0] sides;
      req_valid        = 1'b0;
      req_mode         = MODE_ALLOC;
      req_side_count   = '0;
      req_freed_offset = '0;
      reset            = 1'b1;
      quiet            = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) placed[c] = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // bad side counts at both ends and the all-ones pattern
      send_request(MODE_ALLOC, 8'd0, 26'd0);
      send_request(MODE_ALLOC, 8'd33, 26'd0);
      send_request(MODE_ALLOC, 8'd255, 26'h3FFFFFF);
      // both edges of every class
      send_request(MODE_ALLOC, 8'd1, 26'd0);
      send_request(MODE_ALLOC, 8'd8, 26'd0);
      send_request(MODE_ALLOC, 8'd9, 26'd0);
      send_request(MODE_ALLOC, 8'd16, 26'd0);
      send_request(MODE_ALLOC, 8'd17, 26'd0);
      send_request(MODE_ALLOC, 8'd24, 26'd0);
      send_request(MODE_ALLOC, 8'd25, 26'd0);
      send_request(MODE_ALLOC, 8'd32, 26'd0);
      // free slot zero and get it back
      send_request(MODE_FREE, 8'd0, 26'd0);
      send_request(MODE_ALLOC, 8'd5, 26'd0);
      // unaligned free inside slot one, then the same free again
      send_request(MODE_FREE, 8'd0, 26'd142);
      send_request(MODE_FREE, 8'd0, 26'd142);
      send_request(MODE_ALLOC, 8'd3, 26'd0);
      // class boundaries: last byte of class zero, first byte of class one
      send_request(MODE_FREE, 8'd0, CLASS_BASE_1 - 26'd1);
      send_request(MODE_FREE, 8'd0, CLASS_BASE_1);
      send_request(MODE_FREE, 8'd0, slot_address(3, 1, 1'b0));
      // last byte in the pool, first byte past it, top of the offset range
      send_request(MODE_FREE, 8'd0, POOL_BYTES - 26'd1);
      send_request(MODE_FREE, 8'd0, POOL_BYTES);
      send_request(MODE_FREE, 8'hFF, 26'h3FFFFFF);
      send_request(MODE_ALLOC, 8'd32, 26'd0);

      // mostly frees of taken slots and allocations that refill the holes
      for (int i = 0; i < 1800; i++) begin
         if (i % 300 == 0) quiet = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         cls  = $urandom_range(0, NUM_CLASSES - 1);
         if (pick < 50) begin
            sides = 8'(cls * 8 + $urandom_range(1, 8));
            send_request(MODE_ALLOC, sides, 26'($urandom));
         end else if (pick < 80) begin
            slot = $urandom_range(0, placed[cls] > 0 ? placed[cls] - 1 : 0);
            send_request(MODE_FREE, 8'($urandom), slot_address(cls, slot, $urandom_range(0, 1)));
         end else if (pick < 88) begin
            // raw offsets, a good share of them beyond the pool
            send_request(MODE_FREE, 8'($urandom), 26'($urandom));
         end else if (pick < 95) begin
            // raw side counts, mostly invalid
            send_request(MODE_ALLOC, 8'($urandom), 26'($urandom));
         end else begin
            slot = $urandom_range(0, 1) ? SLOTS_PER_CLASS - 1 : 0;
            send_request(MODE_FREE, 8'($urandom), slot_address(cls, slot, 1'b1));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      quiet = 1'b0;
      while (open_count != 0) @(negedge clock);
      // allow for a stray late response
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
